[sv/aes_block_cipher_unit_macros.svh]
// assertion helpers for the aes block cipher unit
`ifndef AES_BLOCK_CIPHER_UNIT_MACROS_SVH
`define AES_BLOCK_CIPHER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ABC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define ABC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[sv/abc_pkg.sv]
// ----------------------------------------------------------------------------
// abc_pkg
// shared types, constants and round functions of the aes block cipher unit
// ----------------------------------------------------------------------------
package abc_pkg;

  localparam int MaxRoundsDefault = 14;

  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_KEY_W0   = 3'd1;
  localparam logic [2:0] CFG_KEY_W1   = 3'd2;
  localparam logic [2:0] CFG_KEY_W2   = 3'd3;
  localparam logic [2:0] CFG_KEY_W3   = 3'd4;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic kx_init;    // load key words into the expansion window
    logic kx_step;    // produce the next schedule word
    logic kx_write;   // write the four newest window words into the store as a round key
    logic blk_load;   // capture input block and apply first round key
    logic blk_round;  // one full cipher round
    logic blk_last;   // final round without column mixing
    logic out_load;   // move state into the output register
    logic decrypt;
  } abc_cmd_t;

  localparam logic [255:0][7:0] FwdSub = {
    8'h16,8'hbb,8'h54,8'hb0,8'h0f,8'h2d,8'h99,8'h41,8'h68,8'h42,8'he6,8'hbf,8'h0d,8'h89,8'ha1,8'h8c,
    8'hdf,8'h28,8'h55,8'hce,8'he9,8'h87,8'h1e,8'h9b,8'h94,8'h8e,8'hd9,8'h69,8'h11,8'h98,8'hf8,8'he1,
    8'h9e,8'h1d,8'hc1,8'h86,8'hb9,8'h57,8'h35,8'h61,8'h0e,8'hf6,8'h03,8'h48,8'h66,8'hb5,8'h3e,8'h70,
    8'h8a,8'h8b,8'hbd,8'h4b,8'h1f,8'h74,8'hdd,8'he8,8'hc6,8'hb4,8'ha6,8'h1c,8'h2e,8'h25,8'h78,8'hba,
    8'h08,8'hae,8'h7a,8'h65,8'hea,8'hf4,8'h56,8'h6c,8'ha9,8'h4e,8'hd5,8'h8d,8'h6d,8'h37,8'hc8,8'he7,
    8'h79,8'he4,8'h95,8'h91,8'h62,8'hac,8'hd3,8'hc2,8'h5c,8'h24,8'h06,8'h49,8'h0a,8'h3a,8'h32,8'he0,
    8'hdb,8'h0b,8'h5e,8'hde,8'h14,8'hb8,8'hee,8'h46,8'h88,8'h90,8'h2a,8'h22,8'hdc,8'h4f,8'h81,8'h60,
    8'h73,8'h19,8'h5d,8'h64,8'h3d,8'h7e,8'ha7,8'hc4,8'h17,8'h44,8'h97,8'h5f,8'hec,8'h13,8'h0c,8'hcd,
    8'hd2,8'hf3,8'hff,8'h10,8'h21,8'hda,8'hb6,8'hbc,8'hf5,8'h38,8'h9d,8'h92,8'h8f,8'h40,8'ha3,8'h51,
    8'ha8,8'h9f,8'h3c,8'h50,8'h7f,8'h02,8'hf9,8'h45,8'h85,8'h33,8'h4d,8'h43,8'hfb,8'haa,8'hef,8'hd0,
    8'hcf,8'h58,8'h4c,8'h4a,8'h39,8'hbe,8'hcb,8'h6a,8'h5b,8'hb1,8'hfc,8'h20,8'hed,8'h00,8'hd1,8'h53,
    8'h84,8'h2f,8'he3,8'h29,8'hb3,8'hd6,8'h3b,8'h52,8'ha0,8'h5a,8'h6e,8'h1b,8'h1a,8'h2c,8'h83,8'h09,
    8'h75,8'hb2,8'h27,8'heb,8'he2,8'h80,8'h12,8'h07,8'h9a,8'h05,8'h96,8'h18,8'hc3,8'h23,8'hc7,8'h04,
    8'h15,8'h31,8'hd8,8'h71,8'hf1,8'he5,8'ha5,8'h34,8'hcc,8'hf7,8'h3f,8'h36,8'h26,8'h93,8'hfd,8'hb7,
    8'hc0,8'h72,8'ha4,8'h9c,8'haf,8'ha2,8'hd4,8'had,8'hf0,8'h47,8'h59,8'hfa,8'h7d,8'hc9,8'h82,8'hca,
    8'h76,8'hab,8'hd7,8'hfe,8'h2b,8'h67,8'h01,8'h30,8'hc5,8'h6f,8'h6b,8'hf2,8'h7b,8'h77,8'h7c,8'h63
  };

  localparam logic [255:0][7:0] InvSub = {
    8'h7d,8'h0c,8'h21,8'h55,8'h63,8'h14,8'h69,8'he1,8'h26,8'hd6,8'h77,8'hba,8'h7e,8'h04,8'h2b,8'h17,
    8'h61,8'h99,8'h53,8'h83,8'h3c,8'hbb,8'heb,8'hc8,8'hb0,8'hf5,8'h2a,8'hae,8'h4d,8'h3b,8'he0,8'ha0,
    8'hef,8'h9c,8'hc9,8'h93,8'h9f,8'h7a,8'he5,8'h2d,8'h0d,8'h4a,8'hb5,8'h19,8'ha9,8'h7f,8'h51,8'h60,
    8'h5f,8'hec,8'h80,8'h27,8'h59,8'h10,8'h12,8'hb1,8'h31,8'hc7,8'h07,8'h88,8'h33,8'ha8,8'hdd,8'h1f,
    8'hf4,8'h5a,8'hcd,8'h78,8'hfe,8'hc0,8'hdb,8'h9a,8'h20,8'h79,8'hd2,8'hc6,8'h4b,8'h3e,8'h56,8'hfc,
    8'h1b,8'hbe,8'h18,8'haa,8'h0e,8'h62,8'hb7,8'h6f,8'h89,8'hc5,8'h29,8'h1d,8'h71,8'h1a,8'hf1,8'h47,
    8'h6e,8'hdf,8'h75,8'h1c,8'he8,8'h37,8'hf9,8'he2,8'h85,8'h35,8'had,8'he7,8'h22,8'h74,8'hac,8'h96,
    8'h73,8'he6,8'hb4,8'hf0,8'hce,8'hcf,8'hf2,8'h97,8'hea,8'hdc,8'h67,8'h4f,8'h41,8'h11,8'h91,8'h3a,
    8'h6b,8'h8a,8'h13,8'h01,8'h03,8'hbd,8'haf,8'hc1,8'h02,8'h0f,8'h3f,8'hca,8'h8f,8'h1e,8'h2c,8'hd0,
    8'h06,8'h45,8'hb3,8'hb8,8'h05,8'h58,8'he4,8'hf7,8'h0a,8'hd3,8'hbc,8'h8c,8'h00,8'hab,8'hd8,8'h90,
    8'h84,8'h9d,8'h8d,8'ha7,8'h57,8'h46,8'h15,8'h5e,8'hda,8'hb9,8'hed,8'hfd,8'h50,8'h48,8'h70,8'h6c,
    8'h92,8'hb6,8'h65,8'h5d,8'hcc,8'h5c,8'ha4,8'hd4,8'h16,8'h98,8'h68,8'h86,8'h64,8'hf6,8'hf8,8'h72,
    8'h25,8'hd1,8'h8b,8'h6d,8'h49,8'ha2,8'h5b,8'h76,8'hb2,8'h24,8'hd9,8'h28,8'h66,8'ha1,8'h2e,8'h08,
    8'h4e,8'hc3,8'hfa,8'h42,8'h0b,8'h95,8'h4c,8'hee,8'h3d,8'h23,8'hc2,8'ha6,8'h32,8'h94,8'h7b,8'h54,
    8'hcb,8'he9,8'hde,8'hc4,8'h44,8'h43,8'h8e,8'h34,8'h87,8'hff,8'h2f,8'h9b,8'h82,8'h39,8'he3,8'h7c,
    8'hfb,8'hd7,8'hf3,8'h81,8'h9e,8'ha3,8'h40,8'hbf,8'h38,8'ha5,8'h36,8'h30,8'hd5,8'h6a,8'h09,8'h52
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of a 128-bit state, byte 0 in the top bits
  function automatic logic [7:0] sbyte(input logic [127:0] s, input int n);
    return s[127-8*n -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FwdSub[w[31:24]], FwdSub[w[23:16]], FwdSub[w[15:8]], FwdSub[w[7:0]]};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(c*4+r) -: 8] = FwdSub[sbyte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sbyte(t, 4*c);
      a1 = sbyte(t, 4*c+1);
      a2 = sbyte(t, 4*c+2);
      a3 = sbyte(t, 4*c+3);
      m[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                           a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                           a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                           xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    end
    return last ? t : m;
  endfunction

  // inverse mix on all four columns via the 4/5 pre-multiply trick
  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = sbyte(s, 4*c);
      a1 = sbyte(s, 4*c+1);
      a2 = sbyte(s, 4*c+2);
      a3 = sbyte(s, 4*c+3);
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      a0 = a0 ^ u;
      a1 = a1 ^ v;
      a2 = a2 ^ u;
      a3 = a3 ^ v;
      m[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                           a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                           a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                           xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    end
    return m;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(((c + r) % 4) * 4 + r) -: 8] = InvSub[sbyte(s, c*4+r)];
      end
    end
    return t;
  endfunction

endpackage

[sv/aes_block_cipher_unit.sv]
// ----------------------------------------------------------------------------
// aes_block_cipher_unit
// aes-128/192/256 encrypt and decrypt of one block per transaction
// ----------------------------------------------------------------------------
// usage: write key_size and the key words on the cfg port while idle, then
// offer blocks on the in channel (in_valid/in_ready); each block yields one
// transaction on the out channel (out_valid/out_ready).
// the first block after reset or after any key write first expands the key
// schedule into the round key store, one schedule word per cycle.
// rounds run on the single shared round unit, one round per cycle, and
// each round key is read through a register.
// one block is processed at a time; the next is accepted once the previous
// result sits in the output register.
// if the receiver stalls, the result waits in the output register and a
// following block finishes its rounds and holds until it is taken.
// reset is synchronous and clears the key ready flag and handshake state;
// registers return to a 128-bit all-zero key.
// ----------------------------------------------------------------------------
module aes_block_cipher_unit #(
  parameter int MAX_ROUNDS = abc_pkg::MaxRoundsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  abc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output abc_pkg::out_item_t out_item
);

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  logic [1:0]        key_size;
  logic [255:0]      key_bits;
  logic [1:0]        key_sel;
  logic              cfg_touch;
  abc_pkg::abc_cmd_t cmd;
  logic [5:0]        kx_index;
  logic [RW-1:0]     rd_round, wr_round;
  abc_pkg::in_item_t in_hold;

  assign key_sel = (key_size == 2'd3) ? 2'd2 : key_size;

  always_comb begin
    unique case (cfg_index)
      abc_pkg::CFG_KEY_SIZE, abc_pkg::CFG_KEY_W0, abc_pkg::CFG_KEY_W1,
      abc_pkg::CFG_KEY_W2, abc_pkg::CFG_KEY_W3: cfg_touch = cfg_we;
      default: cfg_touch = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= '0;
      key_bits <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abc_pkg::CFG_KEY_SIZE: key_size <= cfg_data[1:0];
        abc_pkg::CFG_KEY_W0:   key_bits[255:192] <= cfg_data;
        abc_pkg::CFG_KEY_W1:   key_bits[191:128] <= cfg_data;
        abc_pkg::CFG_KEY_W2:   key_bits[127:64]  <= cfg_data;
        abc_pkg::CFG_KEY_W3:   key_bits[63:0]    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold <= in_item;
    end
  end

  abc_controller #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
    .clk, .rst, .cfg_touch, .key_sel,
    .in_valid, .in_ready, .in_kind(in_item.kind),
    .out_valid, .out_ready, .cmd, .kx_index, .rd_round, .wr_round
  );

  abc_datapath #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
    .clk, .rst, .cmd, .key_sel, .key_bits, .kx_index, .rd_round, .wr_round,
    .in_item(in_hold), .out_item
  );

endmodule

[sv/abc_datapath.sv]
// ----------------------------------------------------------------------------
// abc_datapath
// key expansion window, round key store, cipher state and output register
// ----------------------------------------------------------------------------
module abc_datapath #(
  parameter int MAX_ROUNDS = abc_pkg::MaxRoundsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  abc_pkg::abc_cmd_t   cmd,
  input  logic [1:0]          key_sel,     // 0, 1, 2 after saturation
  input  logic [255:0]        key_bits,
  input  logic [5:0]          kx_index,    // schedule word being produced
  input  logic [$clog2(MAX_ROUNDS+1)-1:0] rd_round,
  input  logic [$clog2(MAX_ROUNDS+1)-1:0] wr_round,
  input  abc_pkg::in_item_t   in_item,
  output abc_pkg::out_item_t  out_item
);

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  // one 128-bit round key per entry, i.e. four 32-bit schedule words
  logic [127:0] rk_mem [MAX_ROUNDS+1];
  logic [127:0] rk_q;

  // last eight schedule words, newest at index 0
  logic [7:0][31:0] win;
  logic [7:0][31:0] win_next;
  logic [7:0]       rcon;
  logic [31:0]      prev, t;
  logic [2:0]       pos;         // kx_index mod nk
  logic [3:0]       nk;
  logic [31:0]      old;
  logic [11:0]      prod6;
  logic [3:0]       quot6;
  logic [5:0]       rem6;
  logic [127:0]     st;
  logic [127:0]     st_next;
  logic [127:0]     dec_a;

  always_comb begin
    nk = 4'd4 + {1'b0, key_sel, 1'b0};
    // mod 6 by reciprocal multiply, exact for every 6-bit index
    prod6 = {6'd0, kx_index} * 12'd43;
    quot6 = prod6[11:8];
    rem6  = kx_index - ({quot6, 2'b00} + {1'b0, quot6, 1'b0});
    pos = 3'd0;
    unique case (key_sel)
      2'd0:    pos = {1'b0, kx_index[1:0]};
      2'd1:    pos = rem6[2:0];
      default: pos = kx_index[2:0];
    endcase
    prev = win[0];
    old  = win[3'(nk - 4'd1)];
    t    = prev;
    if (pos == 3'd0) begin
      t = abc_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon, 24'h0};
    end else if (key_sel == 2'd2 && pos == 3'd4) begin
      t = abc_pkg::sub_word(prev);
    end
    win_next = {win[6:0], old ^ t};
  end

  always_ff @(posedge clk) begin
    if (cmd.kx_init) begin
      // oldest key word goes highest in the window
      unique case (key_sel)
        2'd0:    win <= {128'h0, key_bits[255:128]};
        2'd1:    win <= {64'h0, key_bits[255:64]};
        default: win <= key_bits;
      endcase
      rcon <= 8'h01;
    end else if (cmd.kx_step) begin
      win <= win_next;
      if (pos == 3'd0) begin
        rcon <= abc_pkg::xtime(rcon);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kx_init) begin
      // round key 0 is the first four key words
      rk_mem[RW'(0)] <= key_bits[255:128];
    end else if (cmd.kx_write) begin
      rk_mem[wr_round] <= {win[3], win[2], win[1], win[0]};
    end
    rk_q <= rk_mem[rd_round];
  end

  assign dec_a = abc_pkg::inv_shift_sub(st) ^ rk_q;

  always_comb begin
    st_next = st;
    if (cmd.blk_load) begin
      st_next = {in_item.block_hi, in_item.block_lo} ^ rk_q;
    end else if (cmd.blk_round || cmd.blk_last) begin
      if (cmd.decrypt) begin
        st_next = cmd.blk_last ? dec_a : abc_pkg::inv_mix(dec_a);
      end else begin
        st_next = abc_pkg::enc_round(st, cmd.blk_last) ^ rk_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    st <= st_next;
    if (cmd.out_load) begin
      out_item <= {st[127:64], st[63:0]};
    end
  end

  logic unused_rst;
  assign unused_rst = rst & (RW > 0);

endmodule

[sv/abc_controller.sv]
// ----------------------------------------------------------------------------
// abc_controller
// sequencer for key expansion, cipher rounds and the result handshake
// ----------------------------------------------------------------------------
`include "aes_block_cipher_unit_macros.svh"

module abc_controller #(
  parameter int MAX_ROUNDS = abc_pkg::MaxRoundsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_touch,   // listed register written
  input  logic [1:0]        key_sel,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  output logic              out_valid,
  input  logic              out_ready,
  output abc_pkg::abc_cmd_t cmd,
  output logic [5:0]        kx_index,
  output logic [$clog2(MAX_ROUNDS+1)-1:0] rd_round,
  output logic [$clog2(MAX_ROUNDS+1)-1:0] wr_round
);

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KINIT = 3'd1;
  localparam logic [2:0] S_KEXP  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state, state_next;
  logic          keys_ready;
  logic          decrypt;
  logic [RW-1:0] rounds;
  logic [RW-1:0] rnd;          // rounds completed
  logic [5:0]    widx;         // words present in the window so far
  logic [5:0]    total;
  logic [3:0]    nk;
  logic          pending;      // result waiting in output register
  logic          in_fire;
  logic          drain;

  always_comb begin
    rounds = (10 + 2 * int'(key_sel) > MAX_ROUNDS) ? RW'(MAX_ROUNDS)
           : RW'(10 + 2 * int'(key_sel));
    nk     = 4'd4 + {1'b0, key_sel, 1'b0};
    total  = 6'(4 * (int'(rounds) + 1));
  end

  assign drain    = out_valid && out_ready;
  assign in_ready = (state == S_IDLE) && !cfg_touch;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = pending;
  assign kx_index = widx;

  // a round key is written each time four new words sit in the window
  assign wr_round = RW'((widx >> 2) - 6'd1);

  always_comb begin
    cmd = '0;
    cmd.decrypt = decrypt;
    state_next = state;
    rd_round = decrypt ? rounds - rnd : rnd;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = keys_ready ? S_FETCH : S_KINIT;
        end
      end
      S_KINIT: begin
        cmd.kx_init = 1'b1;
        state_next = S_KEXP;
      end
      S_KEXP: begin
        // round key 0 is stored at init, later ones as their words complete
        cmd.kx_write = (widx[1:0] == 2'd0) && (widx <= total);
        cmd.kx_step  = (widx < total);
        if (widx >= total) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: state_next = S_LOAD;
      S_LOAD: begin
        cmd.blk_load = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        if (rnd == rounds) begin
          if (!pending || drain) begin
            cmd.out_load = 1'b1;
            state_next = S_DONE;
          end
        end else if (rnd == rounds - RW'(1)) begin
          cmd.blk_last = 1'b1;
        end else begin
          cmd.blk_round = 1'b1;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // prefetch the key of the round after the one in progress
    if (state == S_LOAD) begin
      rd_round = decrypt ? rounds - rnd - RW'(1) : rnd + RW'(1);
    end else if (cmd.blk_round) begin
      rd_round = decrypt ? rounds - rnd - RW'(2) : rnd + RW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      keys_ready <= 1'b0;
      pending    <= 1'b0;
      decrypt    <= 1'b0;
      rnd        <= '0;
      widx       <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        decrypt <= in_kind;
        rnd     <= '0;
      end
      if (state == S_KINIT) begin
        widx <= 6'(nk);
      end else if (cmd.kx_step) begin
        widx <= widx + 6'd1;
      end
      if (state == S_KEXP && widx >= total) begin
        keys_ready <= 1'b1;
      end
      if (cfg_touch) begin
        keys_ready <= 1'b0;
      end
      if (cmd.blk_round || cmd.blk_last) begin
        rnd <= rnd + RW'(1);
      end
      if (cmd.out_load) begin
        pending <= 1'b1;
      end else if (drain) begin
        pending <= 1'b0;
      end
    end
  end

  `ABC_ASSERT_IMP(a_no_accept_busy, state != S_IDLE, !in_ready, "input taken while busy")
  `ABC_ASSERT_NXT(a_load_after_fetch, state == S_FETCH, state == S_LOAD, "fetch not followed by load")
  `ABC_ASSERT_IMP(a_ready_keys, state == S_FETCH, keys_ready, "cipher started without keys")
  `ABC_ASSERT_IMP(a_round_bound, state == S_ROUND, rnd <= rounds, "round count overrun")

endmodule

[verif/aes_block_cipher_unit_tb.sv]
// ----------------------------------------------------------------------------
// aes_block_cipher_unit_tb
// checks encrypt and decrypt results against a behavioural aes model
// ----------------------------------------------------------------------------
// blocks are queued by a stimulus process, driven by a clocked driver and
// collected by a clocked monitor; each result is compared with the oldest
// predicted block. keys and key sizes change between phases while idle.
// ----------------------------------------------------------------------------
module aes_block_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxRounds = abc_pkg::MaxRoundsDefault;
  localparam int CycleLimit = 1500000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  abc_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  abc_pkg::out_item_t out_item;

  aes_block_cipher_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [1:0]         key_len;
  logic [63:0]        key_words [4];
  logic [127:0]       round_keys [MaxRounds+1];
  bit                 schedule_valid;
  abc_pkg::in_item_t  pending_blocks [$];
  abc_pkg::out_item_t expected_blocks [$];
  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 failed;
  int unsigned        cycle_count;

  logic [7:0] sbox_fwd [256];
  logic [7:0] sbox_inv [256];

  function automatic logic [7:0] gf_double(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  // sbox built from the field inverse and the affine map
  task automatic build_sboxes();
    logic [7:0] inv, x, y;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++)
        if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      x = inv;
      y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]} ^ 8'h63;
      sbox_fwd[a] = y;
      sbox_inv[y] = a[7:0];
    end
  endtask

  function automatic int round_count();
    int ks;
    ks = (key_len > 2) ? 2 : key_len;
    return (10 + 2 * ks > MaxRounds) ? MaxRounds : 10 + 2 * ks;
  endfunction

  task automatic expand_schedule();
    logic [31:0] w [4*(MaxRounds+1)];
    logic [31:0] t;
    logic [7:0]  rcon;
    int nk, total;
    nk = 4 + 2 * ((key_len > 2) ? 2 : key_len);
    total = 4 * (round_count() + 1);
    rcon = 8'h01;
    for (int i = 0; i < nk; i++)
      w[i] = i[0] ? key_words[i/2][31:0] : key_words[i/2][63:32];
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_fwd[t[31:24]], sbox_fwd[t[23:16]], sbox_fwd[t[15:8]], sbox_fwd[t[7:0]]}
            ^ {rcon, 24'h0};
        rcon = gf_double(rcon);
      end else if (nk == 8 && i % nk == 4) begin
        t = {sbox_fwd[t[31:24]], sbox_fwd[t[23:16]], sbox_fwd[t[15:8]], sbox_fwd[t[7:0]]};
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int k = 0; 4 * k + 3 < total; k++)
      round_keys[k] = {w[4*k], w[4*k+1], w[4*k+2], w[4*k+3]};
    schedule_valid = 1'b1;
  endtask

  function automatic logic [127:0] shift_state(logic [127:0] s, bit inverse);
    logic [127:0] t;
    int o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        o = ((c + r) % 4) * 4 + r;
        if (inverse) t[127-8*o -: 8] = s[127-8*(c*4+r) -: 8];
        else t[127-8*(c*4+r) -: 8] = s[127-8*o -: 8];
      end
    return t;
  endfunction

  function automatic logic [127:0] sub_state(logic [127:0] s, bit inverse);
    for (int n = 0; n < 16; n++)
      s[127-8*n -: 8] = inverse ? sbox_inv[s[127-8*n -: 8]] : sbox_fwd[s[127-8*n -: 8]];
    return s;
  endfunction

  function automatic logic [127:0] mix_state(logic [127:0] s, bit inverse);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [127:0] t;
    if (inverse) begin
      m = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      m = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = gf_mul(a[r], m[0]) ^ gf_mul(a[(r+1)%4], m[1])
                                ^ gf_mul(a[(r+2)%4], m[2]) ^ gf_mul(a[(r+3)%4], m[3]);
    end
    return t;
  endfunction

  task automatic predict_block(abc_pkg::in_item_t it);
    logic [127:0] s;
    int nr;
    abc_pkg::out_item_t res;
    if (!schedule_valid) expand_schedule();
    nr = round_count();
    s = {it.block_hi, it.block_lo};
    if (it.kind == abc_pkg::KIND_ENCRYPT) begin
      s ^= round_keys[0];
      for (int k = 1; k < nr; k++)
        s = mix_state(shift_state(sub_state(s, 0), 0), 0) ^ round_keys[k];
      s = shift_state(sub_state(s, 0), 0) ^ round_keys[nr];
    end else begin
      s ^= round_keys[nr];
      for (int k = nr - 1; k > 0; k--)
        s = mix_state(sub_state(shift_state(s, 1), 1) ^ round_keys[k], 1);
      s = sub_state(shift_state(s, 1), 1) ^ round_keys[0];
    end
    res.result_hi = s[127:64];
    res.result_lo = s[63:0];
    expected_blocks.push_back(res);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_blocks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item <= pending_blocks.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict at acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_block(in_item);
  end

  // monitor
  always @(posedge clk) begin
    abc_pkg::out_item_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        failed = 1'b1;
      end else begin
        exp_res = expected_blocks.pop_front();
        if (out_item.result_hi !== exp_res.result_hi) begin
          $display("%0t: result_hi expected %h actual %h", $time, exp_res.result_hi,
                   out_item.result_hi);
          failed = 1'b1;
        end
        if (out_item.result_lo !== exp_res.result_lo) begin
          $display("%0t: result_lo expected %h actual %h", $time, exp_res.result_lo,
                   out_item.result_lo);
          failed = 1'b1;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      abc_pkg::CFG_KEY_SIZE: key_len = val[1:0];
      abc_pkg::CFG_KEY_W0:   key_words[0] = val;
      abc_pkg::CFG_KEY_W1:   key_words[1] = val;
      abc_pkg::CFG_KEY_W2:   key_words[2] = val;
      abc_pkg::CFG_KEY_W3:   key_words[3] = val;
      default: return;
    endcase
    schedule_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() > 0 || in_valid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_block(logic kind, logic [63:0] hi, logic [63:0] lo);
    abc_pkg::in_item_t it;
    it.kind = kind;
    it.block_hi = hi;
    it.block_lo = lo;
    pending_blocks.push_back(it);
  endtask

  task automatic load_key(logic [1:0] ks, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    write_reg(abc_pkg::CFG_KEY_SIZE, {62'd0, ks});
    write_reg(abc_pkg::CFG_KEY_W0, k0);
    write_reg(abc_pkg::CFG_KEY_W1, k1);
    write_reg(abc_pkg::CFG_KEY_W2, k2);
    write_reg(abc_pkg::CFG_KEY_W3, k3);
  endtask

  initial begin
    logic [63:0] h, l;
    failed = 1'b0;
    cycle_count = 0;
    send_idle_pct = 9;
    recv_idle_pct = 86;
    key_len = '0;
    key_words = '{default: '0};
    schedule_valid = 1'b0;
    build_sboxes();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset key, fips vectors for each size, extremes
    queue_block(abc_pkg::KIND_ENCRYPT, '0, '0);
    queue_block(abc_pkg::KIND_DECRYPT, '1, '1);
    wait_drained();
    load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
    queue_block(abc_pkg::KIND_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(abc_pkg::KIND_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    wait_drained();
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
    queue_block(abc_pkg::KIND_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(abc_pkg::KIND_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    wait_drained();
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f);
    queue_block(abc_pkg::KIND_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(abc_pkg::KIND_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    queue_block(abc_pkg::KIND_ENCRYPT, '1, '0);
    wait_drained();
    // key size three behaves as a 256-bit key
    load_key(2'd3, '1, '1, '1, '1);
    queue_block(abc_pkg::KIND_ENCRYPT, '1, '1);
    queue_block(abc_pkg::KIND_DECRYPT, '0, '1);
    wait_drained();
    // a write to an unused index leaves the schedule alone
    write_reg(3'd7, '1);
    write_reg(3'd5, 64'h5a5a5a5a5a5a5a5a);
    queue_block(abc_pkg::KIND_ENCRYPT, 64'h8000000000000000, 64'h1);
    wait_drained();
    // rewrite a single word between blocks
    write_reg(abc_pkg::CFG_KEY_W1, 64'h0123456789abcdef);
    queue_block(abc_pkg::KIND_DECRYPT, 64'h1, 64'h8000000000000000);
    wait_drained();

    // random phases with changing keys and idling profiles
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 8) begin
        send_idle_pct = 86;
        recv_idle_pct = 9;
      end else if (ph == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
      for (int i = 0; i < 52; i++) begin
        h = rand64();
        l = rand64();
        case ($urandom_range(9))
          0: h = '0;
          1: l = '1;
          default: ;
        endcase
        queue_block(1'($urandom_range(1)), h, l);
      end
      wait_drained();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
